// ===== src/sdftm_pkg.sv =====
// Package for the sliding single-bin DFT magnitude unit.
// Holds the fixed widths, the quarter-wave sine table, the queue entry type and the
// back-end state type. It has no dependencies.
`default_nettype none
package sdftm_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int PROD_BITS       = 32;
    localparam int SUM_BITS        = 42;
    localparam int MAG_BITS        = 41;
    localparam int RAD_BITS        = 2 * SUM_BITS;
    localparam int ROOT_BITS       = SUM_BITS;
    localparam int WLEN_BITS       = 11;
    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUARTER         = 1 << (TABLE_ADDR_BITS - 2);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [14:0] t_qtab [0:QUARTER];

    // Running sums of one item and its window-full flag, as handed to the back end.
    typedef struct packed {
        logic [SUM_BITS-1:0] sine_sum;
        logic [SUM_BITS-1:0] cosine_sum;
        logic                window_full;
    } t_sums;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQUARE,
        B_ROOT,
        B_DONE
    } t_back_state;

    // Q30 Taylor series of sin(x) to the x^11 term, rounded to Q15.
    function automatic logic [14:0] quarter_sine(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        longint unsigned q;
        x   = (longint'(r) * HALF_PI_Q30) >> (TABLE_ADDR_BITS - 2);
        x2  = (x * x) >> 30;
        t   = x;
        acc = longint'(x);
        t   = ((t * x2) >> 30) / 6;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 20;
        acc = acc + longint'(t);
        t   = ((t * x2) >> 30) / 42;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 72;
        acc = acc + longint'(t);
        t   = ((t * x2) >> 30) / 110;
        acc = acc - longint'(t);
        if (acc < 0) acc = 0;
        q = (longint'(acc) + 16384) >> 15;
        if (q > 32767) q = 32767;
        return q[14:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int r = 0; r <= QUARTER; r++) begin
            tab[r] = quarter_sine(r);
        end
        return tab;
    endfunction

    localparam t_qtab QSIN = build_qtab();

    // Full-turn sine in Q15 from a table phase index.
    function automatic logic signed [15:0] table_sine(input logic [TABLE_ADDR_BITS-1:0] p);
        logic [1:0]                   quad;
        logic [TABLE_ADDR_BITS-3:0]   r;
        logic [TABLE_ADDR_BITS-2:0]   idx;
        logic [15:0]                  mag;
        quad = p[TABLE_ADDR_BITS-1 -: 2];
        r    = p[TABLE_ADDR_BITS-3:0];
        if (quad[0]) idx = (TABLE_ADDR_BITS-1)'(QUARTER) - {1'b0, r};
        else         idx = {1'b0, r};
        mag = {1'b0, QSIN[idx]};
        if (quad[1]) return -signed'(mag);
        return signed'(mag);
    endfunction

endpackage
`default_nettype wire

// ===== src/sdftm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module sdftm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/sdftm_front.sv =====
// Front end: accepts samples, mixes them with table sine and cosine and keeps the
// sliding sums. Depends on sdftm_pkg and sdftm_ram.
`default_nettype none
module sdftm_front #(
    parameter int MAX_WINDOW = sdftm_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [sdftm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic [31:0]                         i_phase_step,
    input  wire logic [sdftm_pkg::WLEN_BITS-1:0]     i_window_len,
    input  wire logic                                i_space,
    output logic                                     o_push,
    output sdftm_pkg::t_sums                         o_sums
);
    import sdftm_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    logic                        r_busy;
    logic [31:0]                 r_phase;
    logic [AW-1:0]               r_wp;
    logic [LEN_W-1:0]            r_fill;
    logic [SUM_BITS-1:0]         r_ssum, r_csum;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [15:0]          r_sin, r_cos;
    logic                        r_sub;
    logic [LEN_W-1:0]            r_len;

    logic                        accept;
    logic [LEN_W-1:0]            len;
    logic [TABLE_ADDR_BITS-1:0]  p, cq;
    logic [AW-1:0]               old_addr;
    logic [LEN_W:0]              wp_ext, len_ext;
    logic [PROD_BITS-1:0]        sp, cp, old_s, old_c;
    logic [SUM_BITS-1:0]         n_ssum, n_csum;
    logic [LEN_W-1:0]            n_fill;

    assign o_ready = !r_busy && i_space;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_window_len == '0)
            len = LEN_W'(1);
        else if ({21'b0, i_window_len} > 32'(MAX_WINDOW))
            len = LEN_W'(MAX_WINDOW);
        else
            len = LEN_W'({21'b0, i_window_len});
    end

    assign p  = r_phase[31 -: TABLE_ADDR_BITS];
    assign cq = p + TABLE_ADDR_BITS'(QUARTER);

    assign wp_ext  = (LEN_W+1)'(r_wp);
    assign len_ext = {1'b0, len};
    always_comb begin
        if (wp_ext >= len_ext) old_addr = AW'(wp_ext - len_ext);
        else                   old_addr = AW'(wp_ext + (LEN_W+1)'(MAX_WINDOW) - len_ext);
    end

    sdftm_ram #(.WIDTH(PROD_BITS), .DEPTH(MAX_WINDOW)) u_sine_ram (
        .i_clk  (i_clk),
        .i_we   (r_busy),
        .i_waddr(r_wp),
        .i_wdata(sp),
        .i_raddr(old_addr),
        .o_rdata(old_s)
    );

    sdftm_ram #(.WIDTH(PROD_BITS), .DEPTH(MAX_WINDOW)) u_cosine_ram (
        .i_clk  (i_clk),
        .i_we   (r_busy),
        .i_waddr(r_wp),
        .i_wdata(cp),
        .i_raddr(old_addr),
        .o_rdata(old_c)
    );

    assign sp = PROD_BITS'(r_x * r_sin);
    assign cp = PROD_BITS'(r_x * r_cos);

    always_comb begin
        n_ssum = r_ssum + {{(SUM_BITS-PROD_BITS){sp[PROD_BITS-1]}}, sp};
        n_csum = r_csum + {{(SUM_BITS-PROD_BITS){cp[PROD_BITS-1]}}, cp};
        if (r_sub) begin
            n_ssum = n_ssum - {{(SUM_BITS-PROD_BITS){old_s[PROD_BITS-1]}}, old_s};
            n_csum = n_csum - {{(SUM_BITS-PROD_BITS){old_c[PROD_BITS-1]}}, old_c};
        end
        n_fill = (r_fill == LEN_W'(MAX_WINDOW)) ? r_fill : r_fill + LEN_W'(1);
    end

    assign o_push              = r_busy;
    assign o_sums.sine_sum     = n_ssum;
    assign o_sums.cosine_sum   = n_csum;
    assign o_sums.window_full  = n_fill >= r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_ssum  <= '0;
            r_csum  <= '0;
        end else begin
            if (accept) begin
                r_busy  <= 1'b1;
                r_phase <= r_phase + i_phase_step;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_ssum <= n_ssum;
                r_csum <= n_csum;
                r_fill <= n_fill;
                r_wp   <= (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_sample;
            r_sin <= table_sine(p);
            r_cos <= table_sine(cq);
            r_sub <= r_fill >= len;
            r_len <= len;
        end
    end
endmodule
`default_nettype wire

// ===== src/sdftm_queue.sv =====
// Short queue of running sums between the front and back ends.
// Depends on sdftm_pkg.
`default_nettype none
module sdftm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sdftm_pkg::t_sums i_data,
    output logic                  o_space,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output sdftm_pkg::t_sums      o_data
);
    import sdftm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_sums          r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    assign o_space = r_count < CW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (i_pop)  r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_space || i_pop)) else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
endmodule
`default_nettype wire

// ===== src/sdftm_back.sv =====
// Back end: squares both sums with a shared multiplier, takes an exact integer square
// root one bit a step and holds the result in an output register. Depends on sdftm_pkg.
`default_nettype none
module sdftm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire sdftm_pkg::t_sums              i_q_data,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [sdftm_pkg::MAG_BITS-1:0]     o_magnitude,
    output logic                               o_window_full
);
    import sdftm_pkg::*;

    localparam int HALF  = SUM_BITS / 2;
    localparam int REM_W = ROOT_BITS + 4;

    t_back_state            r_state, n_state;
    logic [SUM_BITS-1:0]    r_sa, r_ca;
    logic                   r_full;
    logic [2:0]             r_step;
    logic [RAD_BITS-1:0]    r_rad;
    logic [REM_W-1:0]       r_rem;
    logic [ROOT_BITS-1:0]   r_root;
    logic [5:0]             r_cnt;
    logic                   r_out_valid;

    logic                   load_out;
    logic [SUM_BITS-1:0]    sel;
    logic [HALF-1:0]        op_a, op_b;
    logic [SUM_BITS-1:0]    prod;
    logic [RAD_BITS-1:0]    addend;
    logic [REM_W-1:0]       rem_sh, trial;
    logic [SUM_BITS-1:0]    abs_s, abs_c;

    assign abs_s = i_q_data.sine_sum[SUM_BITS-1]   ? -i_q_data.sine_sum   : i_q_data.sine_sum;
    assign abs_c = i_q_data.cosine_sum[SUM_BITS-1] ? -i_q_data.cosine_sum : i_q_data.cosine_sum;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (i_q_valid) n_state = B_SQUARE;
            B_SQUARE: if (r_step == 3'd5) n_state = B_ROOT;
            B_ROOT:   if (r_cnt == 6'(ROOT_BITS - 1)) n_state = B_DONE;
            B_DONE:   if (!r_out_valid || i_ready) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            B_IDLE:  o_pop    = i_q_valid;
            B_DONE:  load_out = !r_out_valid || i_ready;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Each square is lo*lo + 2*hi*lo*2^HALF + hi*hi*2^(2*HALF).
    always_comb begin
        sel = (r_step < 3'd3) ? r_sa : r_ca;
        case (r_step)
            3'd0, 3'd3: begin op_a = sel[HALF-1:0];          op_b = sel[HALF-1:0]; end
            3'd1, 3'd4: begin op_a = sel[SUM_BITS-1:HALF];   op_b = sel[HALF-1:0]; end
            default:    begin op_a = sel[SUM_BITS-1:HALF];   op_b = sel[SUM_BITS-1:HALF]; end
        endcase
        prod = SUM_BITS'(op_a * op_b);
        case (r_step)
            3'd0, 3'd3: addend = RAD_BITS'(prod);
            3'd1, 3'd4: addend = RAD_BITS'(prod) << (HALF + 1);
            default:    addend = RAD_BITS'(prod) << (2 * HALF);
        endcase
    end

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_BITS-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)     r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_sa   <= abs_s;
                r_ca   <= abs_c;
                r_full <= i_q_data.window_full;
                r_step <= '0;
                r_rad  <= '0;
            end
            B_SQUARE: begin
                r_rad  <= r_rad + addend;
                r_step <= r_step + 3'd1;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            B_ROOT: begin
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + 6'd1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                end
            end
            default: r_cnt <= r_cnt;
        endcase
        if (load_out) begin
            o_magnitude   <= r_root[ROOT_BITS-1:MAG_BITS] != '0 ? '1 : r_root[MAG_BITS-1:0];
            o_window_full <= r_full;
        end
    end

    assign o_valid = r_out_valid;

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == B_IDLE) else $error("pop outside idle");
    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_state == B_IDLE && r_out_valid) else $error("load lost");
    a_root_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SQUARE && r_step == 3'd5) |=> r_state == B_ROOT && r_cnt == '0)
        else $error("root did not start clean");
endmodule
`default_nettype wire

// ===== src/sliding_single_bin_dft_magnitude_unit.sv =====
// Top level of the sliding single-bin DFT magnitude unit: configuration registers and
// the front end, queue and back end. Depends on sdftm_pkg and all sdftm_* modules.
`default_nettype none
//  channel   direction  handshake            payload
//  sample    in         i_valid / o_ready    i_sample (16 bit signed)
//  result    out        o_valid / i_ready    o_magnitude (41 bit), o_window_full
//  config    in         APB psel/penable     paddr[2:0], pwdata, prdata (32 bit)
//
// The front end takes a new sample only once it is through with the last one: it first
// registers the table lookup and the read of the product memories, then does the
// multiply, sum update and write. The back end pops the queue only while idle; it forms
// six partial squares on one shared multiplier, then the root bit by bit, and loads
// the result into the output register. Reset is synchronous and active low; the
// product memories need no clearing pass. A stalled output holds its result while the
// back end and a two-entry queue keep the front end taking samples until the queue fills.
module sliding_single_bin_dft_magnitude_unit #(
    parameter int MAX_WINDOW = sdftm_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [sdftm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic [sdftm_pkg::MAG_BITS-1:0]                o_magnitude,
    output logic                                          o_window_full,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [2:0]                               paddr,
    input  wire logic [31:0]                              pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);
    import sdftm_pkg::*;

    // Register 0 (phase_step) sits at address 0, register 1 (window_len) at 4.
    logic [31:0]          r_phase_step;
    logic [WLEN_BITS-1:0] r_window_len;
    logic                 cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_window_len <= WLEN_BITS'(1024);
        end else if (cfg_we) begin
            if (paddr[2]) r_window_len <= pwdata[WLEN_BITS-1:0];
            else          r_phase_step <= pwdata;
        end
    end

    assign prdata = paddr[2] ? {21'b0, r_window_len} : r_phase_step;

    logic  q_space, q_push, q_pop, q_valid;
    t_sums f_sums, q_sums;

    sdftm_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_phase_step(r_phase_step),
        .i_window_len(r_window_len),
        .i_space     (q_space),
        .o_push      (q_push),
        .o_sums      (f_sums)
    );

    sdftm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (f_sums),
        .o_space(q_space),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_sums)
    );

    sdftm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_sums),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_magnitude  (o_magnitude),
        .o_window_full(o_window_full)
    );
endmodule
`default_nettype wire

// ===== sim/sliding_single_bin_dft_magnitude_unit_tb.sv =====
// Self-checking testbench for sliding_single_bin_dft_magnitude_unit.
// A directed table followed by random configured phases, checked against an
// in-bench predictor. Depends on sdftm_pkg and the unit's RTL.
`timescale 1ns / 100ps
module sliding_single_bin_dft_magnitude_unit_tb;
    import sdftm_pkg::*;

    localparam logic [2:0] REG_PHASE_STEP = 3'd0;
    localparam logic [2:0] REG_WINDOW_LEN = 3'd4;
    localparam int         HIST_DEPTH     = 1024;
    localparam int         RANDOM_ITEMS   = 410;
    localparam int         SETTLE_CYCLES  = 150;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } t_row_kind;

    // One row of the directed table: either a register write or a sample,
    // the latter optionally with a hand-computed expected result.
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  addr;
        logic [31:0] value;
        bit          typed;
        logic [40:0] mag;
        logic        full;
    } t_row;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic                full;
    } t_bin_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [MAG_BITS-1:0]           o_magnitude;
    logic                          o_window_full;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    sliding_single_bin_dft_magnitude_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_magnitude   (o_magnitude),
        .o_window_full (o_window_full),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state: its own copy of the registers, the phase, the product
    // history and the two running sums.
    logic [31:0]               cfg_step = '0;
    logic [10:0]               cfg_len = 11'd1024;
    logic [31:0]               phase_now = '0;
    logic signed [31:0]        sin_hist [HIST_DEPTH];
    logic signed [31:0]        cos_hist [HIST_DEPTH];
    logic [SUM_BITS-1:0]       sin_acc = '0;
    logic [SUM_BITS-1:0]       cos_acc = '0;
    int                        fill_cnt = 0;
    int                        wr_idx = 0;
    logic [15:0]               quarter_rom [0:256];

    t_bin_result               pending_bins [$];
    int                        fails = 0;
    bit                        quiet = 1'b0;   // no idling on either side while set

    // Quarter-wave sine in Q15 from a truncated Q30 Taylor series.
    function automatic logic [15:0] quarter_value(input int r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        longint          q;
        x   = (longint'(r) * 64'd1686629713) >> 8;
        x2  = (x * x) >> 30;
        t   = x;
        acc = longint'(x);
        for (int k = 1; k <= 5; k++) begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(t);
            else            acc = acc + longint'(t);
        end
        if (acc < 0) acc = 0;
        q = (acc + 16384) >>> 15;
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    function automatic logic signed [16:0] full_sine(input logic [9:0] p);
        logic [8:0]         idx;
        logic signed [16:0] v;
        idx = p[8] ? 9'd256 - {1'b0, p[7:0]} : {1'b0, p[7:0]};
        v   = signed'({1'b0, quarter_rom[idx]});
        return p[9] ? -v : v;
    endfunction

    function automatic logic [SUM_BITS-1:0] abs42(input logic [SUM_BITS-1:0] v);
        return v[SUM_BITS-1] ? -v : v;
    endfunction

    // Advances the predictor by one sample and returns the result it causes.
    function automatic t_bin_result next_bin(input logic signed [15:0] s);
        logic [9:0]          p;
        int                  len;
        int                  old;
        logic signed [31:0]  sp;
        logic signed [31:0]  cp;
        logic [SUM_BITS-1:0] a;
        logic [SUM_BITS-1:0] b;
        logic [87:0]         energy;
        logic [87:0]         root;
        logic [87:0]         cand;
        t_bin_result         res;
        p   = phase_now[31:22];
        len = cfg_len;
        if (len == 0) len = 1;
        if (len > HIST_DEPTH) len = HIST_DEPTH;
        sp = 32'(s * full_sine(p));
        cp = 32'(s * full_sine(p + 10'd256));
        if (fill_cnt >= len) begin
            old     = (wr_idx + HIST_DEPTH - len) % HIST_DEPTH;
            sin_acc = sin_acc - SUM_BITS'(sin_hist[old]);
            cos_acc = cos_acc - SUM_BITS'(cos_hist[old]);
        end
        sin_acc = sin_acc + SUM_BITS'(sp);
        cos_acc = cos_acc + SUM_BITS'(cp);
        sin_hist[wr_idx] = sp;
        cos_hist[wr_idx] = cp;
        wr_idx = (wr_idx + 1) % HIST_DEPTH;
        if (fill_cnt < HIST_DEPTH) fill_cnt++;
        phase_now = phase_now + cfg_step;
        a      = abs42(sin_acc);
        b      = abs42(cos_acc);
        energy = 88'(a) * 88'(a) + 88'(b) * 88'(b);
        root   = '0;
        for (int bit_i = 43; bit_i >= 0; bit_i--) begin
            cand = root | (88'd1 << bit_i);
            if (cand * cand <= energy) root = cand;
        end
        if (root > ((88'd1 << MAG_BITS) - 88'd1)) root = (88'd1 << MAG_BITS) - 88'd1;
        res.mag  = root[MAG_BITS-1:0];
        res.full = (fill_cnt >= len);
        return res;
    endfunction

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 33);
    endfunction

    // Offers one sample and waits for its acceptance. Valid stays high after
    // the item so that back-to-back items need no extra assignment.
    task automatic send_sample(input logic signed [15:0] s, input bit typed,
                               input t_bin_result hand);
        int          gap;
        t_bin_result pred;
        gap = 0;
        while (idle_roll()) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        pred = next_bin(s);
        pending_bins.push_back(typed ? hand : pred);
    endtask

    // Stops the sample stream, waits for every result and for the back end to
    // settle, so the registers can be written safely.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_PHASE_STEP) cfg_step = value;
        else                        cfg_len  = value[10:0];
    endtask

    // Receiver: random back-pressure and the comparison with the oldest
    // expectation.
    always @(posedge i_clk) begin
        i_ready <= !idle_roll();
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: result with none expected: mag %0d full %0b",
                         $time, o_magnitude, o_window_full);
                fails++;
            end else begin
                if (o_magnitude !== pending_bins[0].mag) begin
                    $display("%0t: magnitude expected %0d actual %0d",
                             $time, pending_bins[0].mag, o_magnitude);
                    fails++;
                end
                if (o_window_full !== pending_bins[0].full) begin
                    $display("%0t: window_full expected %0b actual %0b",
                             $time, pending_bins[0].full, o_window_full);
                    fails++;
                end
                void'(pending_bins.pop_front());
            end
        end
    end

    initial begin
        #5_000_000;
        $display("sliding_single_bin_dft_magnitude_unit_tb failed");
        $finish;
    end

    initial begin
        t_row        dir_rows [$];
        t_bin_result hand;
        logic [31:0] step_pick;
        logic [10:0] len_pick;
        logic signed [15:0] s;
        int          sent;
        int          phase_cnt;

        for (int r = 0; r <= 256; r++) quarter_rom[r] = quarter_value(r);

        // Window of one at phase zero: the sine sum is zero and the cosine
        // factor is 32767, so the magnitude is simply |sample| * 32767.
        dir_rows = '{
            '{ROW_WRITE,  REG_WINDOW_LEN, 32'd1,          0, 41'd0,          1'b0},
            '{ROW_WRITE,  REG_PHASE_STEP, 32'd0,          0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(16'sd32767),          1, 41'd1073676289, 1'b1},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd32768),         1, 41'd1073709056, 1'b1},
            '{ROW_SAMPLE, 3'd0, 32'd0,                    1, 41'd0,          1'b1},
            '{ROW_SAMPLE, 3'd0, 32'd1,                    1, 41'd32767,      1'b1},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd1),             1, 41'd32767,      1'b1},
            // A zero window length behaves as a length of one.
            '{ROW_WRITE,  REG_WINDOW_LEN, 32'd0,          0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'd100,                  1, 41'd3276700,    1'b1},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd100),           1, 41'd3276700,    1'b1},
            // An oversized length saturates to the full store: not yet full.
            '{ROW_WRITE,  REG_WINDOW_LEN, 32'd2047,       0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'd5,                    0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd32768),         0, 41'd0,          1'b0},
            // Quarter-turn step with a short window that refills.
            '{ROW_WRITE,  REG_PHASE_STEP, 32'h4000_0000,  0, 41'd0,          1'b0},
            '{ROW_WRITE,  REG_WINDOW_LEN, 32'd4,          0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(16'sd32767),          0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd32768),         0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'd12345,                0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd1),             0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'd0,                    0, 41'd0,          1'b0},
            // Largest step: the phase walks backwards by one LSB per sample.
            '{ROW_WRITE,  REG_PHASE_STEP, 32'hFFFF_FFFF,  0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(-16'sd32768),         0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'(16'sd32767),          0, 41'd0,          1'b0},
            '{ROW_SAMPLE, 3'd0, 32'd7,                    0, 41'd0,          1'b0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                drain();
                write_reg(dir_rows[i].addr, dir_rows[i].value);
            end else begin
                hand.mag  = dir_rows[i].mag;
                hand.full = dir_rows[i].full;
                send_sample(dir_rows[i].value[15:0], dir_rows[i].typed, hand);
            end
        end

        // Random phases, each with its own setting; the first few pin the
        // extremes, and one phase runs with no idling on either side.
        sent      = 0;
        phase_cnt = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase_cnt)
                0: begin step_pick = 32'hFFFF_FFFF; len_pick = 11'd1;    end
                1: begin step_pick = 32'd0;         len_pick = 11'd1024; end
                2: begin step_pick = 32'd1;         len_pick = 11'd2;    end
                3: begin step_pick = $urandom();    len_pick = 11'd2047; end
                default: begin
                    step_pick = ($urandom_range(1) == 1) ? $urandom()
                                                         : $urandom_range(32'h0100_0000);
                    len_pick  = ($urandom_range(3) == 0) ? 11'($urandom_range(2047))
                                                         : 11'($urandom_range(64, 1));
                end
            endcase
            drain();
            write_reg(REG_PHASE_STEP, step_pick);
            write_reg(REG_WINDOW_LEN, {21'd0, len_pick});
            quiet = (phase_cnt == 4);
            repeat ($urandom_range(70, 30)) begin
                case ($urandom_range(9))
                    0:       s = 16'sh7FFF;
                    1:       s = 16'sh8000;
                    2:       s = 16'(int'($urandom_range(15)) - 8);
                    default: s = 16'($urandom());
                endcase
                hand = '0;
                send_sample(s, 1'b0, hand);
                sent++;
            end
            quiet = 1'b0;
            phase_cnt++;
        end

        drain();
        if (fails == 0) begin
            $display("sliding_single_bin_dft_magnitude_unit_tb passed");
        end else begin
            $display("sliding_single_bin_dft_magnitude_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/sdftm_pkg.sv
src/sdftm_ram.sv
src/sdftm_front.sv
src/sdftm_queue.sv
src/sdftm_back.sv
src/sliding_single_bin_dft_magnitude_unit.sv
sim/sliding_single_bin_dft_magnitude_unit_tb.sv
